/* hw/rtl/ptw_pkg.sv */
// Shared types, sizes and codes of the radix page table walker.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package ptw_pkg;

	// Geometry of the frame store and of the walk.
	localparam int FRAMES     = 64;
	localparam int LEVELS     = 5;
	localparam int INDEX_BITS = 10;

	// Fixed field widths of the ports.
	localparam int VPN_W     = 50;
	localparam int PPN_W     = 51;
	localparam int ROOT_W    = 6;
	localparam int BASE_W    = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;

	// Derived sizes.
	localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int ADDR_W    = FRAME_W + INDEX_BITS;
	localparam int MEM_DEPTH = FRAMES << INDEX_BITS;
	localparam int WALK_W    = LEVELS * INDEX_BITS;
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int TAKEN_W   = $clog2(FRAMES + 1);
	localparam int NF_W      = ((TAKEN_W > BASE_W) ? TAKEN_W : BASE_W) + 1;
	// A stored entry keeps the valid bit and the 51-bit frame or page number.
	localparam int ENTRY_W   = PPN_W + 1;

	// Request codes.
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MAP    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// Response status codes.
	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NONE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_FRAME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOC_BASE = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_FAIL,
		S_DONE
	} ptw_state_t;

	// Source of the data written into the frame store.
	typedef enum logic [1:0] {
		WR_ZERO,
		WR_TABLE,
		WR_LEAF
	} ptw_wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              clr;
		logic              load_item;
		logic              rd_en;
		logic              wr_en;
		ptw_wr_sel_t       wr_sel;
		logic              advance;
		logic              take_alloc;
		logic              set_res;
		logic [STAT_W-1:0] res_status;
		logic              res_found;
		logic              load_out;
	} ptw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic root_bad;
		logic entry_valid;
		logic next_bad;
		logic alloc_full;
		logic is_map;
		logic is_remove;
		logic last_level;
	} ptw_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/ptw_ctrl.sv */
// Walk controller: state machine that sequences the clear pass, the table
// reads, allocation and leaf writes, and the response handshake. Uses ptw_pkg.
`default_nettype none

module ptw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	input  wire ptw_pkg::ptw_stat_t stat,
	output ptw_pkg::ptw_cmd_t      cmd
);

	ptw_pkg::ptw_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptw_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptw_pkg::S_CLEAR: begin
				if (stat.clr_done) begin
					state_d = ptw_pkg::S_IDLE;
				end
			end
			ptw_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = stat.root_bad ? ptw_pkg::S_FAIL : ptw_pkg::S_READ;
				end
			end
			ptw_pkg::S_READ: begin
				state_d = ptw_pkg::S_EVAL;
			end
			ptw_pkg::S_EVAL: begin
				if (stat.last_level) begin
					state_d = ptw_pkg::S_DONE;
				end else if (stat.entry_valid) begin
					state_d = stat.next_bad ? ptw_pkg::S_FAIL : ptw_pkg::S_READ;
				end else if (stat.is_map && !stat.alloc_full) begin
					state_d = ptw_pkg::S_READ;
				end else begin
					state_d = ptw_pkg::S_FAIL;
				end
			end
			ptw_pkg::S_FAIL: begin
				state_d = ptw_pkg::S_DONE;
			end
			ptw_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ptw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptw_pkg::S_CLEAR;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd        = '0;
		cmd.wr_sel = ptw_pkg::WR_ZERO;
		req_stall  = 1'b1;
		case (state_q)
			ptw_pkg::S_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ptw_pkg::S_IDLE: begin
				req_stall     = 1'b0;
				cmd.load_item = req_valid;
			end
			ptw_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
			end
			ptw_pkg::S_EVAL: begin
				if (stat.last_level) begin
					cmd.set_res = 1'b1;
					if (stat.is_map) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_sel     = ptw_pkg::WR_LEAF;
						cmd.res_status = ptw_pkg::STATUS_OK;
					end else begin
						cmd.wr_en      = stat.is_remove;
						cmd.res_status = stat.entry_valid ? ptw_pkg::STATUS_OK
						                                  : ptw_pkg::STATUS_NONE;
						cmd.res_found  = stat.entry_valid && !stat.is_remove;
					end
				end else if (stat.entry_valid) begin
					cmd.advance = !stat.next_bad;
				end else if (stat.is_map && !stat.alloc_full) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = ptw_pkg::WR_TABLE;
					cmd.advance    = 1'b1;
					cmd.take_alloc = 1'b1;
				end
			end
			ptw_pkg::S_FAIL: begin
				cmd.set_res    = 1'b1;
				cmd.res_status = stat.is_map ? ptw_pkg::STATUS_FULL : ptw_pkg::STATUS_NONE;
			end
			ptw_pkg::S_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd.clr = 1'b0;
			end
		endcase
	end

	// The store has a single port: a read never shares a cycle with a write.
	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && (cmd.wr_en || cmd.clr)))
		else $error("frame store read and write in the same cycle");

	// After a request is taken, the next one waits for the walk to finish.
	a_one_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while a walk is in progress");

	// A response appears only out of the final state of a walk.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ptw_pkg::S_DONE)
		else $error("response raised outside the done state");

	// No request is taken while the store is still being cleared.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptw_pkg::S_CLEAR) |-> (req_stall && !rsp_valid))
		else $error("traffic during the clear pass");

endmodule

`default_nettype wire

/* hw/rtl/ptw_dp.sv */
// Walk datapath: frame store, configuration registers, bump allocator, walk
// registers and response registers. Driven by ptw_ctrl; uses ptw_pkg.
`default_nettype none

module ptw_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ptw_pkg::ptw_cmd_t             cmd,
	output ptw_pkg::ptw_stat_t                 stat,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ptw_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [ptw_pkg::ACT_W-1:0]     action,
	input  wire logic [ptw_pkg::VPN_W-1:0]     vpn,
	input  wire logic [ptw_pkg::PPN_W-1:0]     ppn,
	output logic [ptw_pkg::STAT_W-1:0]         status,
	output logic [ptw_pkg::PPN_W-1:0]          found_ppn
);

	// Frame store and its registered read data.
	logic [ptw_pkg::ENTRY_W-1:0] frame_store_q [ptw_pkg::MEM_DEPTH];
	logic [ptw_pkg::ENTRY_W-1:0] rd_q;

	// Configuration and allocator state.
	logic [ptw_pkg::ROOT_W-1:0]  root_frame_q;
	logic [ptw_pkg::BASE_W-1:0]  alloc_base_q;
	logic [ptw_pkg::TAKEN_W-1:0] frames_taken_q;
	logic [ptw_pkg::ADDR_W-1:0]  clr_cnt_q;

	// Walk state.
	logic [ptw_pkg::ACT_W-1:0]   action_q;
	logic [ptw_pkg::WALK_W-1:0]  vpn_sh_q;
	logic [ptw_pkg::PPN_W-1:0]   ppn_q;
	logic [ptw_pkg::FRAME_W-1:0] frame_q;
	logic [ptw_pkg::LVL_W-1:0]   level_q;
	logic [ptw_pkg::STAT_W-1:0]  res_status_q;
	logic [ptw_pkg::PPN_W-1:0]   res_ppn_q;
	logic [ptw_pkg::STAT_W-1:0]  status_q;
	logic [ptw_pkg::PPN_W-1:0]   found_ppn_q;

	logic [ptw_pkg::INDEX_BITS-1:0] walk_idx;
	logic [ptw_pkg::ADDR_W-1:0]     walk_addr;
	logic [ptw_pkg::ADDR_W-1:0]     mem_addr;
	logic [ptw_pkg::ENTRY_W-1:0]    wr_data;
	logic [ptw_pkg::PPN_W-1:0]      rd_value;
	logic [ptw_pkg::NF_W-1:0]       next_free;

	// The vpn is kept left-aligned and shifted one index per level.
	assign walk_idx  = vpn_sh_q[ptw_pkg::WALK_W-1 -: ptw_pkg::INDEX_BITS];
	assign walk_addr = {frame_q, walk_idx};
	assign mem_addr  = cmd.clr ? clr_cnt_q : walk_addr;
	assign rd_value  = rd_q[ptw_pkg::ENTRY_W-1:1];
	assign next_free = ptw_pkg::NF_W'(alloc_base_q) + ptw_pkg::NF_W'(frames_taken_q);

	always_comb begin
		case (cmd.wr_sel)
			ptw_pkg::WR_TABLE: wr_data = {ptw_pkg::PPN_W'(next_free), 1'b1};
			ptw_pkg::WR_LEAF:  wr_data = {ppn_q, 1'b1};
			default:           wr_data = '0;
		endcase
	end

	assign stat.clr_done    = (32'(clr_cnt_q) == ptw_pkg::MEM_DEPTH - 1);
	assign stat.root_bad    = (32'(root_frame_q) >= ptw_pkg::FRAMES);
	assign stat.entry_valid = rd_q[0];
	assign stat.next_bad    = (rd_value >= ptw_pkg::PPN_W'(ptw_pkg::FRAMES));
	assign stat.alloc_full  = (next_free >= ptw_pkg::NF_W'(ptw_pkg::FRAMES));
	assign stat.is_map      = (action_q == ptw_pkg::ACT_MAP);
	assign stat.is_remove   = (action_q == ptw_pkg::ACT_REMOVE);
	assign stat.last_level  = (level_q == ptw_pkg::LVL_W'(ptw_pkg::LEVELS - 1));

	// Single-port frame store.
	always_ff @(posedge clk) begin
		if (cmd.clr || cmd.wr_en) begin
			frame_store_q[mem_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= frame_store_q[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q   <= '0;
			alloc_base_q   <= ptw_pkg::BASE_W'(1);
			frames_taken_q <= '0;
			clr_cnt_q      <= '0;
			level_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ptw_pkg::REG_ROOT_FRAME: root_frame_q <= cfg_data[ptw_pkg::ROOT_W-1:0];
					ptw_pkg::REG_ALLOC_BASE: alloc_base_q <= cfg_data[ptw_pkg::BASE_W-1:0];
					default:                 root_frame_q <= root_frame_q;
				endcase
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.take_alloc) begin
				frames_taken_q <= frames_taken_q + 1'b1;
			end
			if (cmd.load_item) begin
				level_q <= '0;
			end else if (cmd.advance) begin
				level_q <= level_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= action;
			vpn_sh_q <= ptw_pkg::WALK_W'(vpn);
			ppn_q    <= ppn;
			frame_q  <= ptw_pkg::FRAME_W'(root_frame_q);
		end else if (cmd.advance) begin
			vpn_sh_q <= vpn_sh_q << ptw_pkg::INDEX_BITS;
			frame_q  <= cmd.take_alloc ? next_free[ptw_pkg::FRAME_W-1:0]
			                           : rd_value[ptw_pkg::FRAME_W-1:0];
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_ppn_q    <= cmd.res_found ? rd_value : '0;
		end
		if (cmd.load_out) begin
			status_q    <= res_status_q;
			found_ppn_q <= res_ppn_q;
		end
	end

	assign status    = status_q;
	assign found_ppn = found_ppn_q;

	// The walk never steps past the leaf level.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(level_q) <= ptw_pkg::LEVELS - 1)
		else $error("walk level out of range");

	// Frames are never handed back.
	a_taken_grows: assert property (@(posedge clk) disable iff (!arst_n)
		frames_taken_q >= $past(frames_taken_q))
		else $error("allocator count went backwards");

	// A table frame is taken only when the allocator still has one.
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_alloc |-> !stat.alloc_full)
		else $error("allocation past the last frame");

endmodule

`default_nettype wire

/* hw/rtl/radix_page_table_walker_core.sv */
// Top level of the radix page table walker: joins the walk controller and
// the walk datapath. Depends on ptw_pkg, ptw_ctrl and ptw_dp.
`default_nettype none

// The walker keeps a five-level radix page table in an internal store of
// 64 frames of 1024 entries each and serves query, map and remove requests,
// one transaction at a time. After reset the store is swept to zero one
// entry per cycle; req_stall stays high for that time, while configuration
// writes are taken at once. Each level of a walk on the single-port frame
// store is a read, then the evaluation with any table or leaf write. A
// finished walk loads the response register, and the next request can be
// taken in the cycle after it is loaded. The response is registered: a new
// request is taken while an earlier response still waits under rsp_stall,
// and the walk holds in its last state only if the response register is
// still occupied. Map requests take missing intermediate tables from a bump
// allocator starting at alloc_base; when it runs out the response is out of
// frames and tables taken so far remain linked. Remove clears the leaf only
// when the full path exists and never frees tables. Configuration writes
// (root_frame at index 0, alloc_base at index 1) are meant for an idle block.
module radix_page_table_walker_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          cfg_wr_en,
	input  wire logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ptw_pkg::CFG_W-1:0]     cfg_data,
	// Request channel.
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [ptw_pkg::ACT_W-1:0]     action,
	input  wire logic [ptw_pkg::VPN_W-1:0]     vpn,
	input  wire logic [ptw_pkg::PPN_W-1:0]     ppn,
	// Response channel.
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [ptw_pkg::STAT_W-1:0]         status,
	output logic [ptw_pkg::PPN_W-1:0]          found_ppn
);

	ptw_pkg::ptw_cmd_t  cmd;
	ptw_pkg::ptw_stat_t stat;

	// The controller sequences each walk and owns both handshakes.
	ptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the store, the allocator and the payload registers.
	ptw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.vpn       (vpn),
		.ppn       (ppn),
		.status    (status),
		.found_ppn (found_ppn)
	);

endmodule

`default_nettype wire
